// ===== sv/dti_pkg.sv =====
package dti_pkg;

    localparam int POINTS_DEF    = 256;
    localparam int MATERIALS_DEF = 4;

    localparam logic [1:0] MODE_LOAD_REAL = 2'd0;
    localparam logic [1:0] MODE_LOAD_IMAG = 2'd1;
    localparam logic [1:0] MODE_QUERY     = 2'd2;
    localparam logic [1:0] MODE_CLEAR     = 2'd3;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_RANGE   = 2'd1;
    localparam logic [1:0] STATUS_FULL    = 2'd2;
    localparam logic [1:0] STATUS_NO_DATA = 2'd3;

    typedef struct packed {
        logic [1:0]         mode;
        logic [1:0]         material_select;
        logic [31:0]        wavelength;
        logic signed [31:0] real_index;
        logic signed [31:0] imag_index;
    } item_t;

    typedef struct packed {
        logic               start;
        logic [31:0]        wl;
        logic [31:0]        wh;
        logic signed [31:0] pl;
        logic signed [31:0] ph;
        logic [31:0]        x;
    } lerp_req_t;

endpackage

// ===== sv/dti_ram.sv =====
module dti_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/dti_front.sv =====
module dti_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  dti_pkg::item_t push_item,
    output logic          full,
    input  logic          pop,
    output logic          q_valid,
    output dti_pkg::item_t q_item
);

    dti_pkg::item_t slot_reg [2];
    logic           wptr_reg;
    logic           rptr_reg;
    logic [1:0]     cnt_reg;
    logic           do_push;
    logic           do_pop;

    assign full    = (cnt_reg == 2'd2);
    assign q_valid = (cnt_reg != 2'd0);
    assign q_item  = slot_reg[rptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && q_valid;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wptr_reg <= ~wptr_reg;
            end
            if (do_pop)
            begin
                rptr_reg <= ~rptr_reg;
            end
            if (do_push && !do_pop)
            begin
                cnt_reg <= cnt_reg + 2'd1;
            end
            else if (do_pop && !do_push)
            begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

endmodule

// ===== sv/dti_lerp.sv =====
module dti_lerp (
    input  logic                clk,
    input  logic                rst_n,
    input  dti_pkg::lerp_req_t  req,
    output logic                done,
    output logic signed [31:0]  res
);

    typedef enum logic [1:0] {L_IDLE, L_MUL, L_DIV, L_FIN} lstate_t;

    lstate_t            state_reg;
    logic [6:0]         cnt_reg;
    logic [31:0]        dw_reg;
    logic [31:0]        t_reg;
    logic [32:0]        mag_reg;
    logic               neg_reg;
    logic signed [31:0] pl_reg;
    logic [64:0]        acc_reg;
    logic [32:0]        rem_reg;
    logic [32:0]        q_reg;
    logic               done_reg;
    logic signed [31:0] res_reg;

    logic signed [32:0] diff;
    logic [33:0]        r2;
    logic               ge;

    assign diff = 33'(req.ph) - 33'(req.pl);
    assign r2   = {rem_reg, acc_reg[64]};
    assign ge   = (r2 >= {2'b00, dw_reg});

    assign done = done_reg;
    assign res  = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= L_IDLE;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
            dw_reg    <= '0;
            t_reg     <= '0;
            mag_reg   <= '0;
            neg_reg   <= 1'b0;
            pl_reg    <= '0;
            acc_reg   <= '0;
            rem_reg   <= '0;
            q_reg     <= '0;
            res_reg   <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                L_IDLE:
                begin
                    if (req.start)
                    begin
                        dw_reg  <= req.wh - req.wl;
                        t_reg   <= req.x - req.wl;
                        neg_reg <= diff[32];
                        mag_reg <= diff[32] ? 33'(-diff) : 33'(diff);
                        pl_reg  <= req.pl;
                        acc_reg <= '0;
                        cnt_reg <= 7'd31;
                        if (req.wh == req.wl)
                        begin
                            res_reg  <= req.pl;
                            done_reg <= 1'b1;
                        end
                        else
                        begin
                            state_reg <= L_MUL;
                        end
                    end
                end
                L_MUL:
                begin
                    acc_reg <= (acc_reg << 1) + (t_reg[cnt_reg[4:0]] ? 65'(mag_reg) : 65'd0);
                    if (cnt_reg == 7'd0)
                    begin
                        state_reg <= L_FIN;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg - 7'd1;
                    end
                end
                L_FIN:
                begin
                    acc_reg   <= acc_reg + 65'(dw_reg >> 1);
                    rem_reg   <= '0;
                    q_reg     <= '0;
                    cnt_reg   <= 7'd64;
                    state_reg <= L_DIV;
                end
                L_DIV:
                begin
                    acc_reg <= acc_reg << 1;
                    q_reg   <= {q_reg[31:0], ge};
                    rem_reg <= ge ? 33'(r2 - {2'b00, dw_reg}) : r2[32:0];
                    if (cnt_reg == 7'd0)
                    begin
                        state_reg <= L_IDLE;
                        done_reg  <= 1'b1;
                        res_reg   <= neg_reg
                            ? 32'(34'(pl_reg) - $signed({1'b0, q_reg[31:0], ge}))
                            : 32'(34'(pl_reg) + $signed({1'b0, q_reg[31:0], ge}));
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg - 7'd1;
                    end
                end
                default:
                begin
                    state_reg <= L_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== sv/dti_back.sv =====
module dti_back #(
    parameter int POINTS    = dti_pkg::POINTS_DEF,
    parameter int MATERIALS = dti_pkg::MATERIALS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    input  dti_pkg::item_t      q_item,
    output logic                pop,
    output logic                strobe,
    output logic [1:0]          status,
    output logic signed [31:0]  real_out,
    output logic signed [31:0]  imag_out
);

    localparam int DEPTH = MATERIALS * POINTS;
    localparam int AW    = $clog2(DEPTH);
    localparam int PW    = $clog2(POINTS);
    localparam int CW    = $clog2(POINTS + 1);
    localparam int MW    = (MATERIALS > 1) ? $clog2(MATERIALS) : 1;

    typedef enum logic [3:0] {
        S_IDLE, S_DEC, S_W0, S_U0, S_W1, S_U1, S_WS, S_US,
        S_LSET, S_LW0, S_LU0, S_LW1, S_LU1, S_LGO, S_LRUN
    } state_t;

    state_t             state_reg;
    dti_pkg::item_t     item_reg;
    logic [CW-1:0]      rcnt_reg [MATERIALS];
    logic [CW-1:0]      icnt_reg [MATERIALS];
    logic               loaded_reg [MATERIALS];
    logic               tsel_reg;
    logic               lp_reg;
    logic [PW-1:0]      idx_reg;
    logic [PW-1:0]      lo_reg;
    logic [PW-1:0]      hi_reg;
    logic [PW-1:0]      rlo_reg;
    logic [PW-1:0]      ilo_reg;
    logic [31:0]        wl_reg;
    logic [31:0]        wh_reg;
    logic signed [31:0] pl_reg;
    logic signed [31:0] ph_reg;
    logic signed [31:0] rv_reg;
    logic               strobe_reg;
    logic [1:0]         status_reg;
    logic signed [31:0] real_reg;
    logic signed [31:0] imag_reg;

    logic [MW-1:0]      mi;
    logic               sel_bad;
    logic [CW-1:0]      nr;
    logic [CW-1:0]      ni;
    logic [CW-1:0]      n_cur;
    logic [AW-1:0]      base;
    logic [AW-1:0]      raddr;
    logic [31:0]        rw_q;
    logic signed [31:0] rp_q;
    logic signed [31:0] ri_q;
    logic [31:0]        iw_q;
    logic signed [31:0] ip_q;
    logic [31:0]        wd;
    logic signed [31:0] pd;
    logic               we_real;
    logic               we_imag;
    logic [AW-1:0]      waddr_real;
    logic [AW-1:0]      waddr_imag;
    logic [PW-1:0]      c_lo;
    logic [PW-1:0]      c_hi;
    logic [PW-1:0]      c_mid;
    logic               use_imag;
    dti_pkg::lerp_req_t lreq;
    logic               l_done;
    logic signed [31:0] l_res;

    assign mi       = MW'(item_reg.material_select);
    assign sel_bad  = (32'(item_reg.material_select) >= MATERIALS);
    assign nr       = rcnt_reg[mi];
    assign ni       = icnt_reg[mi];
    assign n_cur    = tsel_reg ? ni : nr;
    assign base     = AW'(mi) * AW'(POINTS);
    assign raddr    = base + AW'(idx_reg);
    assign wd       = tsel_reg ? iw_q : rw_q;
    assign use_imag = (ni != '0);
    assign pop      = (state_reg == S_IDLE) && q_valid;

    always_comb
    begin
        if (!lp_reg)
        begin
            pd = rp_q;
        end
        else if (tsel_reg)
        begin
            pd = ip_q;
        end
        else
        begin
            pd = ri_q;
        end
    end

    assign we_real    = (state_reg == S_DEC) && !sel_bad
                        && (item_reg.mode == dti_pkg::MODE_LOAD_REAL)
                        && (nr < CW'(POINTS));
    assign we_imag    = (state_reg == S_DEC) && !sel_bad
                        && (item_reg.mode == dti_pkg::MODE_LOAD_IMAG)
                        && (ni < CW'(POINTS));
    assign waddr_real = base + AW'(nr);
    assign waddr_imag = base + AW'(ni);

    always_comb
    begin
        if (state_reg == S_U1)
        begin
            c_lo = '0;
            c_hi = PW'(n_cur - CW'(1));
        end
        else if (wd <= item_reg.wavelength)
        begin
            c_lo = c_mid;
            c_hi = hi_reg;
        end
        else
        begin
            c_lo = lo_reg;
            c_hi = c_mid;
        end
    end

    assign c_mid = lo_reg + ((hi_reg - lo_reg) >> 1);

    dti_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_real_w (
        .clk(clk), .we(we_real), .waddr(waddr_real), .wdata(item_reg.wavelength),
        .raddr(raddr), .rdata(rw_q)
    );
    dti_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_real_p (
        .clk(clk), .we(we_real), .waddr(waddr_real), .wdata(item_reg.real_index),
        .raddr(raddr), .rdata(rp_q)
    );
    dti_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_real_i (
        .clk(clk), .we(we_real), .waddr(waddr_real), .wdata(item_reg.imag_index),
        .raddr(raddr), .rdata(ri_q)
    );
    dti_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_imag_w (
        .clk(clk), .we(we_imag), .waddr(waddr_imag), .wdata(item_reg.wavelength),
        .raddr(raddr), .rdata(iw_q)
    );
    dti_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_imag_p (
        .clk(clk), .we(we_imag), .waddr(waddr_imag), .wdata(item_reg.imag_index),
        .raddr(raddr), .rdata(ip_q)
    );

    assign lreq.start = (state_reg == S_LGO);
    assign lreq.wl    = wl_reg;
    assign lreq.wh    = wh_reg;
    assign lreq.pl    = pl_reg;
    assign lreq.ph    = ph_reg;
    assign lreq.x     = item_reg.wavelength;

    dti_lerp u_lerp (
        .clk(clk), .rst_n(rst_n), .req(lreq), .done(l_done), .res(l_res)
    );

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            item_reg <= q_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            tsel_reg   <= 1'b0;
            lp_reg     <= 1'b0;
            idx_reg    <= '0;
            lo_reg     <= '0;
            hi_reg     <= '0;
            rlo_reg    <= '0;
            ilo_reg    <= '0;
            wl_reg     <= '0;
            wh_reg     <= '0;
            pl_reg     <= '0;
            ph_reg     <= '0;
            rv_reg     <= '0;
            strobe_reg <= 1'b0;
            status_reg <= dti_pkg::STATUS_OK;
            real_reg   <= '0;
            imag_reg   <= '0;
            for (int m = 0; m < MATERIALS; m++)
            begin
                rcnt_reg[m]   <= '0;
                icnt_reg[m]   <= '0;
                loaded_reg[m] <= 1'b0;
            end
        end
        else
        begin
            strobe_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (pop)
                    begin
                        state_reg <= S_DEC;
                    end
                end
                S_DEC:
                begin
                    real_reg   <= '0;
                    imag_reg   <= '0;
                    status_reg <= dti_pkg::STATUS_OK;
                    strobe_reg <= 1'b1;
                    state_reg  <= S_IDLE;
                    if (sel_bad)
                    begin
                        status_reg <= dti_pkg::STATUS_NO_DATA;
                    end
                    else
                    begin
                        case (item_reg.mode)
                            dti_pkg::MODE_LOAD_REAL:
                            begin
                                if (we_real)
                                begin
                                    rcnt_reg[mi]   <= nr + CW'(1);
                                    loaded_reg[mi] <= 1'b1;
                                end
                                else
                                begin
                                    status_reg <= dti_pkg::STATUS_FULL;
                                end
                            end
                            dti_pkg::MODE_LOAD_IMAG:
                            begin
                                if (we_imag)
                                begin
                                    icnt_reg[mi]   <= ni + CW'(1);
                                    loaded_reg[mi] <= 1'b1;
                                end
                                else
                                begin
                                    status_reg <= dti_pkg::STATUS_FULL;
                                end
                            end
                            dti_pkg::MODE_CLEAR:
                            begin
                                rcnt_reg[mi]   <= '0;
                                icnt_reg[mi]   <= '0;
                                loaded_reg[mi] <= 1'b0;
                            end
                            default:
                            begin
                                if (!loaded_reg[mi] || nr < CW'(2) || ni == CW'(1))
                                begin
                                    status_reg <= dti_pkg::STATUS_NO_DATA;
                                end
                                else
                                begin
                                    strobe_reg <= 1'b0;
                                    tsel_reg   <= 1'b0;
                                    idx_reg    <= '0;
                                    state_reg  <= S_W0;
                                end
                            end
                        endcase
                    end
                end
                S_W0:
                begin
                    state_reg <= S_U0;
                end
                S_U0:
                begin
                    if (item_reg.wavelength < wd)
                    begin
                        status_reg <= dti_pkg::STATUS_RANGE;
                        strobe_reg <= 1'b1;
                        state_reg  <= S_IDLE;
                    end
                    else
                    begin
                        idx_reg   <= PW'(n_cur - CW'(1));
                        state_reg <= S_W1;
                    end
                end
                S_W1:
                begin
                    state_reg <= S_U1;
                end
                S_WS:
                begin
                    state_reg <= S_US;
                end
                S_U1, S_US:
                begin
                    if (state_reg == S_U1 && item_reg.wavelength > wd)
                    begin
                        status_reg <= dti_pkg::STATUS_RANGE;
                        strobe_reg <= 1'b1;
                        state_reg  <= S_IDLE;
                    end
                    else
                    begin
                        lo_reg <= c_lo;
                        hi_reg <= c_hi;
                        if (c_hi - c_lo > PW'(1))
                        begin
                            idx_reg   <= c_lo + ((c_hi - c_lo) >> 1);
                            state_reg <= S_WS;
                        end
                        else if (!tsel_reg)
                        begin
                            rlo_reg <= c_lo;
                            lp_reg  <= 1'b0;
                            if (use_imag)
                            begin
                                tsel_reg  <= 1'b1;
                                idx_reg   <= '0;
                                state_reg <= S_W0;
                            end
                            else
                            begin
                                state_reg <= S_LSET;
                            end
                        end
                        else
                        begin
                            ilo_reg   <= c_lo;
                            lp_reg    <= 1'b0;
                            state_reg <= S_LSET;
                        end
                    end
                end
                S_LSET:
                begin
                    tsel_reg  <= lp_reg && use_imag;
                    idx_reg   <= (lp_reg && use_imag) ? ilo_reg : rlo_reg;
                    state_reg <= S_LW0;
                end
                S_LW0:
                begin
                    state_reg <= S_LU0;
                end
                S_LU0:
                begin
                    wl_reg    <= wd;
                    pl_reg    <= pd;
                    idx_reg   <= idx_reg + PW'(1);
                    state_reg <= S_LW1;
                end
                S_LW1:
                begin
                    state_reg <= S_LU1;
                end
                S_LU1:
                begin
                    wh_reg    <= wd;
                    ph_reg    <= pd;
                    state_reg <= S_LGO;
                end
                S_LGO:
                begin
                    state_reg <= S_LRUN;
                end
                S_LRUN:
                begin
                    if (l_done)
                    begin
                        if (!lp_reg)
                        begin
                            rv_reg    <= l_res;
                            lp_reg    <= 1'b1;
                            state_reg <= S_LSET;
                        end
                        else
                        begin
                            real_reg   <= rv_reg;
                            imag_reg   <= (l_res == 32'sh8000_0000) ? 32'sh7fff_ffff : -l_res;
                            status_reg <= dti_pkg::STATUS_OK;
                            strobe_reg <= 1'b1;
                            state_reg  <= S_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign strobe   = strobe_reg;
    assign status   = status_reg;
    assign real_out = real_reg;
    assign imag_out = imag_reg;

endmodule

// ===== sv/dispersion_table_interpolator.sv =====
// Sequence: a load or clear is taken from the queue, decoded and answered with a strobe;
// a query binary-searches the real table, then the imag table if it holds points,
// reading the registered table RAMs, and then runs two bit-serial interpolations.
// The back end handles one item at a time; a two-entry queue takes up to two more items.
// Reset: asynchronous, active low; empties the queue and all point counts.
// Results cannot be stalled by the receiver.
module dispersion_table_interpolator #(
    parameter int POINTS    = dti_pkg::POINTS_DEF,
    parameter int MATERIALS = dti_pkg::MATERIALS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         mode,
    input  logic [1:0]         material_select,
    input  logic [31:0]        wavelength,
    input  logic signed [31:0] real_index,
    input  logic signed [31:0] imag_index,
    output logic               strobe,
    output logic [1:0]         status,
    output logic signed [31:0] real_out,
    output logic signed [31:0] imag_out
);

    dti_pkg::item_t in_item;
    dti_pkg::item_t q_item;
    logic           q_valid;
    logic           pop;

    assign in_item.mode            = mode;
    assign in_item.material_select = material_select;
    assign in_item.wavelength      = wavelength;
    assign in_item.real_index      = real_index;
    assign in_item.imag_index      = imag_index;

    dti_front u_front (
        .clk(clk), .rst_n(rst_n), .push(start), .push_item(in_item), .full(busy),
        .pop(pop), .q_valid(q_valid), .q_item(q_item)
    );

    dti_back #(.POINTS(POINTS), .MATERIALS(MATERIALS)) u_back (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_item(q_item), .pop(pop),
        .strobe(strobe), .status(status), .real_out(real_out), .imag_out(imag_out)
    );

endmodule

// ===== sim/dispersion_table_interpolator_test.sv =====
`timescale 1ns / 100ps

module dispersion_table_interpolator_test;

    localparam int NPTS = dti_pkg::POINTS_DEF;
    localparam int NMAT = dti_pkg::MATERIALS_DEF;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] real_out;
        logic signed [31:0] imag_out;
    } answer_t;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [1:0]         mode;
    logic [1:0]         material_select;
    logic [31:0]        wavelength;
    logic signed [31:0] real_index;
    logic signed [31:0] imag_index;
    logic               strobe;
    logic [1:0]         status;
    logic signed [31:0] real_out;
    logic signed [31:0] imag_out;

    dispersion_table_interpolator dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .mode(mode),
        .material_select(material_select), .wavelength(wavelength),
        .real_index(real_index), .imag_index(imag_index), .strobe(strobe),
        .status(status), .real_out(real_out), .imag_out(imag_out)
    );

    logic [31:0]        rw_tab [NMAT][NPTS];
    logic signed [31:0] rp_tab [NMAT][NPTS];
    logic signed [31:0] ri_tab [NMAT][NPTS];
    logic [31:0]        iw_tab [NMAT][NPTS];
    logic signed [31:0] ip_tab [NMAT][NPTS];
    int                 real_cnt [NMAT] = '{default: 0};
    int                 imag_cnt [NMAT] = '{default: 0};
    bit                 has_load [NMAT] = '{default: 0};

    dti_pkg::item_t pending_items[$];
    answer_t expected_answers[$];
    int      send_idle_pct = 0;
    int      failures = 0;
    int      accepted = 0;
    int      answered = 0;
    int      queries_ok = 0;
    int      quiet_cycles = 0;
    bit      took = 0;

    function automatic int find_bracket(input int m, input bit imag_tab, input int n,
                                        input logic [31:0] x);
        int lo;
        int hi;
        int mid;
        logic [31:0] w;
        lo = 0;
        hi = n - 1;
        if (x < (imag_tab ? iw_tab[m][0] : rw_tab[m][0])) return -1;
        if (x > (imag_tab ? iw_tab[m][hi] : rw_tab[m][hi])) return -1;
        while (hi - lo > 1) begin
            mid = lo + (hi - lo) / 2;
            w = imag_tab ? iw_tab[m][mid] : rw_tab[m][mid];
            if (w <= x) lo = mid;
            else hi = mid;
        end
        return lo;
    endfunction

    function automatic longint interp(input logic [31:0] wl, input logic [31:0] wh,
                                      input longint pl, input longint ph,
                                      input logic [31:0] x);
        longint unsigned dw;
        longint unsigned t;
        longint unsigned mag;
        longint unsigned q;
        longint diff;
        dw = longint'(wh) - longint'(wl);
        if (dw == 0) return pl;
        t = longint'(x) - longint'(wl);
        diff = ph - pl;
        mag = diff < 0 ? -diff : diff;
        q = (mag * t + dw / 2) / dw;
        return diff < 0 ? pl - longint'(q) : pl + longint'(q);
    endfunction

    function automatic answer_t apply_item(input dti_pkg::item_t it);
        answer_t a;
        int m;
        int nr;
        int ni;
        int lo;
        int ilo;
        longint im;
        longint iv;
        a = '0;
        m = it.material_select;
        if (m >= NMAT) begin
            a.status = dti_pkg::STATUS_NO_DATA;
            return a;
        end
        nr = real_cnt[m];
        ni = imag_cnt[m];
        case (it.mode)
            dti_pkg::MODE_LOAD_REAL:
                if (nr >= NPTS) a.status = dti_pkg::STATUS_FULL;
                else begin
                    rw_tab[m][nr] = it.wavelength;
                    rp_tab[m][nr] = it.real_index;
                    ri_tab[m][nr] = it.imag_index;
                    real_cnt[m]++;
                    has_load[m] = 1;
                end
            dti_pkg::MODE_LOAD_IMAG:
                if (ni >= NPTS) a.status = dti_pkg::STATUS_FULL;
                else begin
                    iw_tab[m][ni] = it.wavelength;
                    ip_tab[m][ni] = it.imag_index;
                    imag_cnt[m]++;
                    has_load[m] = 1;
                end
            dti_pkg::MODE_CLEAR: begin
                real_cnt[m] = 0;
                imag_cnt[m] = 0;
                has_load[m] = 0;
            end
            default: begin
                ilo = 0;
                if (!has_load[m] || nr < 2 || ni == 1) a.status = dti_pkg::STATUS_NO_DATA;
                else begin
                    lo = find_bracket(m, 0, nr, it.wavelength);
                    if (ni != 0 && lo >= 0) ilo = find_bracket(m, 1, ni, it.wavelength);
                    if (lo < 0 || ilo < 0) a.status = dti_pkg::STATUS_RANGE;
                    else begin
                        a.real_out = 32'(interp(rw_tab[m][lo], rw_tab[m][lo+1],
                            rp_tab[m][lo], rp_tab[m][lo+1], it.wavelength));
                        if (ni == 0)
                            im = interp(rw_tab[m][lo], rw_tab[m][lo+1], ri_tab[m][lo],
                                        ri_tab[m][lo+1], it.wavelength);
                        else
                            im = interp(iw_tab[m][ilo], iw_tab[m][ilo+1], ip_tab[m][ilo],
                                        ip_tab[m][ilo+1], it.wavelength);
                        iv = -im;
                        if (iv > 64'sd2147483647) iv = 64'sd2147483647;
                        a.imag_out = 32'(iv);
                    end
                end
            end
        endcase
        return a;
    endfunction

    function automatic dti_pkg::item_t make_item(input logic [1:0] md, input logic [1:0] ms,
                                                 input logic [31:0] w, input logic [31:0] r,
                                                 input logic [31:0] i);
        dti_pkg::item_t it;
        it.mode = md;
        it.material_select = ms;
        it.wavelength = w;
        it.real_index = r;
        it.imag_index = i;
        return it;
    endfunction

    task automatic push(input dti_pkg::item_t it);
        pending_items.push_back(it);
    endtask

    task automatic drain();
        while (pending_items.size() != 0 || expected_answers.size() != 0)
            @(posedge clk);
        repeat (400) @(posedge clk);
    endtask

    // sorted table with random content, followed by queries in and around its range
    task automatic random_table_set(input int m);
        int n;
        int ni;
        int k;
        logic [31:0] w;
        logic [31:0] step;
        push(make_item(dti_pkg::MODE_CLEAR, 2'(m), $urandom, $urandom, $urandom));
        n = $urandom_range(2, 10);
        w = $urandom_range(0, 1000);
        step = ($urandom_range(0, 3) == 0) ? 32'd300000000 : 32'd2000;
        for (k = 0; k < n; k++) begin
            push(make_item(dti_pkg::MODE_LOAD_REAL, 2'(m), w, $urandom, $urandom));
            w = w + $urandom_range(0, step);
        end
        ni = $urandom_range(0, 2) == 0 ? $urandom_range(2, 6) : 0;
        w = $urandom_range(0, 1000);
        for (k = 0; k < ni; k++) begin
            push(make_item(dti_pkg::MODE_LOAD_IMAG, 2'(m), w, $urandom, $urandom));
            w = w + $urandom_range(0, step);
        end
        for (k = 0; k < $urandom_range(4, 12); k++)
            push(make_item(dti_pkg::MODE_QUERY, 2'(m),
                           $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, w),
                           $urandom, $urandom));
    endtask

    initial begin
        clk = 0;
        forever #1 clk = ~clk;
    end

    always @(negedge clk or negedge rst_n) begin
        if (!rst_n) begin
            start <= 0;
            mode <= '0;
            material_select <= '0;
            wavelength <= '0;
            real_index <= '0;
            imag_index <= '0;
        end
        else if ((!start || took) && pending_items.size() != 0
                 && $urandom_range(0, 99) >= send_idle_pct) begin
            start <= 1;
            {mode, material_select, wavelength, real_index, imag_index}
                <= pending_items[0];
        end
        else if (!start || took) begin
            start <= 0;
        end
    end

    always @(posedge clk) begin
        if (rst_n) begin
            took = start && !busy;
            if (took || strobe)
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (took) begin
                expected_answers.push_back(apply_item(pending_items.pop_front()));
                accepted++;
            end
            if (strobe) begin
                if (expected_answers.size() == 0) begin
                    $error("unexpected result status=%0d", status);
                    failures++;
                end
                else begin
                    answer_t e;
                    e = expected_answers.pop_front();
                    answered++;
                    if (e.status == dti_pkg::STATUS_OK && e.real_out != 0) queries_ok++;
                    if (status !== e.status) begin
                        $error("status: expected %0d actual %0d", e.status, status);
                        failures++;
                    end
                    if (real_out !== e.real_out) begin
                        $error("real_out: expected %0d actual %0d", e.real_out, real_out);
                        failures++;
                    end
                    if (imag_out !== e.imag_out) begin
                        $error("imag_out: expected %0d actual %0d", e.imag_out, imag_out);
                        failures++;
                    end
                end
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog expired");
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    initial begin
        int k;
        int p;
        rst_n = 0;
        repeat (11) @(posedge clk);
        rst_n = 1;

        push(make_item(dti_pkg::MODE_QUERY, 2'd0, 32'd5, 32'd0, 32'd0));
        push(make_item(dti_pkg::MODE_LOAD_REAL, 2'd0, 32'd100, 32'sh7fffffff, 32'sh80000000));
        push(make_item(dti_pkg::MODE_QUERY, 2'd0, 32'd100, 32'd0, 32'd0));
        push(make_item(dti_pkg::MODE_LOAD_REAL, 2'd0, 32'd100, 32'sh80000000, 32'sh7fffffff));
        push(make_item(dti_pkg::MODE_LOAD_REAL, 2'd0, 32'hffffffff, 32'sh7fffffff,
                       32'sh80000000));
        push(make_item(dti_pkg::MODE_QUERY, 2'd0, 32'd100, 32'd0, 32'd0));
        push(make_item(dti_pkg::MODE_QUERY, 2'd0, 32'd99, 32'd0, 32'd0));
        push(make_item(dti_pkg::MODE_QUERY, 2'd0, 32'hffffffff, 32'd0, 32'd0));
        push(make_item(dti_pkg::MODE_QUERY, 2'd0, 32'h80000000, 32'd0, 32'd0));
        push(make_item(dti_pkg::MODE_LOAD_IMAG, 2'd0, 32'd0, 32'd0, 32'sh80000000));
        push(make_item(dti_pkg::MODE_QUERY, 2'd0, 32'h80000000, 32'd0, 32'd0));
        push(make_item(dti_pkg::MODE_LOAD_IMAG, 2'd0, 32'd1000, 32'hffffffff, 32'sh7fffffff));
        push(make_item(dti_pkg::MODE_QUERY, 2'd0, 32'd500, 32'd0, 32'd0));
        push(make_item(dti_pkg::MODE_QUERY, 2'd0, 32'd2000, 32'd0, 32'd0));
        push(make_item(dti_pkg::MODE_LOAD_REAL, 2'd3, 32'd50, 32'd1, 32'd2));
        push(make_item(dti_pkg::MODE_LOAD_REAL, 2'd3, 32'd10, 32'd3, 32'd4));
        push(make_item(dti_pkg::MODE_QUERY, 2'd3, 32'd30, 32'd0, 32'd0));
        push(make_item(dti_pkg::MODE_CLEAR, 2'd0, 32'd0, 32'd0, 32'd0));
        push(make_item(dti_pkg::MODE_QUERY, 2'd0, 32'd100, 32'd0, 32'd0));
        drain();

        // fill one table to capacity, then overflow it
        for (k = 0; k < NPTS + 2; k++)
            push(make_item(dti_pkg::MODE_LOAD_REAL, 2'd1, 32'(k * 7), $urandom, $urandom));
        push(make_item(dti_pkg::MODE_LOAD_IMAG, 2'd1, 32'd0, 32'd0, 32'd5));
        push(make_item(dti_pkg::MODE_QUERY, 2'd1, 32'd900, 32'd0, 32'd0));
        push(make_item(dti_pkg::MODE_CLEAR, 2'd1, 32'd0, 32'd0, 32'd0));
        drain();

        for (p = 0; p < 4; p++) begin
            send_idle_pct = (p == 1) ? 70 : (p == 3 ? 36 : 0);
            for (k = 0; k < 4; k++) begin
                random_table_set($urandom_range(0, NMAT - 1));
                if ($urandom_range(0, 4) == 0)
                    push(make_item(2'($urandom), 2'($urandom), $urandom, $urandom,
                                   $urandom));
            end
            drain();
        end
        $display("Covered %0d transfers, %0d results, %0d nonzero interpolations",
                 accepted, answered, queries_ok);
        $display("Loads, clears, full tables, range misses and empty tables exercised");
        if (failures == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
